@@ hw/rtl/upr_pkg.sv @@
// Shared types, codes and constants of the UDP port receive queues.
package upr_pkg;

  localparam int unsigned PORT_SLOTS_DEF = 64;
  localparam int unsigned RING_DEPTH_DEF = 16;

  localparam logic [12:0] HDR_LEN     = 13'd42;
  localparam logic [16:0] IP_UDP_BASE = 17'd34;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  typedef enum logic [1:0] {
    OP_BIND    = 2'd0,
    OP_UNBIND  = 2'd1,
    OP_DELIVER = 2'd2,
    OP_RECEIVE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PORT   = 3'd1,
    ST_BOUND      = 3'd2,
    ST_UNBOUND    = 3'd3,
    ST_NOT_UDP    = 3'd4,
    ST_FULL       = 3'd5,
    ST_EMPTY_FRM  = 3'd6,
    ST_RING_EMPTY = 3'd7
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] port;
    logic [31:0] frame_handle;
    logic [12:0] frame_length;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_length;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [12:0] max_length;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_handle;
    logic        release_handle;
    logic [31:0] out_source_ip;
    logic [15:0] out_source_port;
    logic [16:0] payload_offset;
    logic [12:0] byte_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic desc_rd;
    logic finish_lookup;
    logic finish_desc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic need_desc;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/upr_req_if.sv @@
// Request channel: one command word per handshake.
interface upr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] port;
  logic [31:0] frame_handle;
  logic [12:0] frame_length;
  logic [7:0]  ip_protocol;
  logic [15:0] udp_length;
  logic [31:0] source_ip;
  logic [15:0] source_port;
  logic [12:0] max_length;

  modport source (
    output valid, opcode, port, frame_handle, frame_length, ip_protocol,
           udp_length, source_ip, source_port, max_length,
    input  ready
  );
  modport sink (
    input  valid, opcode, port, frame_handle, frame_length, ip_protocol,
           udp_length, source_ip, source_port, max_length,
    output ready
  );
endinterface

@@ hw/rtl/upr_rsp_if.sv @@
// Response channel: one result word per handshake.
interface upr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_handle;
  logic        release_handle;
  logic [31:0] out_source_ip;
  logic [15:0] out_source_port;
  logic [16:0] payload_offset;
  logic [12:0] byte_count;

  modport source (
    output valid, status, out_handle, release_handle, out_source_ip,
           out_source_port, payload_offset, byte_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, release_handle, out_source_ip,
           out_source_port, payload_offset, byte_count,
    output ready
  );
endinterface

@@ hw/rtl/upr_ctrl.sv @@
// Controller state machine of the UDP port receive queues.
module upr_ctrl import upr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DESC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        if (req_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        priority if (sts.need_desc) begin
          cmd.desc_rd = 1'b1;
          state_next  = S_DESC;
        end else if (sts.out_free) begin
          cmd.finish_lookup = 1'b1;
          state_next        = S_IDLE;
        end else begin
          // The output register is still held, so the result waits here.
          state_next = S_LOOKUP;
        end
      end
      S_DESC: begin
        if (sts.out_free) begin
          cmd.finish_desc = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // A word taken in always leads to a table lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_LOOKUP))
    else $error("accepted word not followed by lookup");

  // A result is never written while the output register is still held.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish_lookup || cmd.finish_desc) |-> sts.out_free)
    else $error("result written over a pending word");

  // A descriptor read always ends in a descriptor finish state.
  a_desc_path: assert property (@(posedge clk) disable iff (rst)
    cmd.desc_rd |=> (state == S_DESC))
    else $error("descriptor read without descriptor stage");

endmodule

@@ hw/rtl/upr_dp.sv @@
// Datapath: port table, descriptor store, decision logic and output register.
module upr_dp import upr_pkg::*; #(
  parameter int unsigned PORT_SLOTS = PORT_SLOTS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_in,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp_out,
  output logic rsp_valid,
  input  logic rsp_ready
);

  localparam int unsigned PW    = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int unsigned HW    = $clog2(RING_DEPTH);
  localparam int unsigned CW    = $clog2(RING_DEPTH + 1);
  localparam int unsigned DEPTH = PORT_SLOTS * RING_DEPTH;
  localparam int unsigned DW    = $clog2(DEPTH);

  typedef struct packed {
    logic          bound;
    logic [HW-1:0] head;
    logic [HW-1:0] tail;
    logic [CW-1:0] count;
  } slot_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [16:0] end_off;
    logic [31:0] sip;
    logic [15:0] sport;
  } desc_t;

  // Latched request.
  req_t          req_q;
  logic          port_ok;
  logic [PW-1:0] pidx;

  always_ff @(posedge clk) begin
    if (cmd.accept) req_q <= req_in;
  end

  assign port_ok = {1'b0, req_q.port} < 17'(PORT_SLOTS);
  assign pidx    = req_q.port[PW-1:0];

  // Port table with clearing pass after reset.
  slot_t         slot_mem [PORT_SLOTS];
  slot_t         slot_rd;
  logic [PW-1:0] clr_idx;
  logic          slot_we;
  logic [PW-1:0] slot_wa;
  slot_t         slot_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + PW'(1);
    end
  end

  assign sts.clr_last = (clr_idx == PW'(PORT_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.accept) slot_rd <= slot_mem[req_in.port[PW-1:0]];
  end

  // Descriptor store; entries are read only after a deliver wrote them.
  desc_t         desc_mem [DEPTH];
  logic [16:0]   off_mem  [DEPTH];
  desc_t         desc_rd;
  logic [16:0]   off_rd;
  logic [DW-1:0] head_addr;
  logic [DW-1:0] tail_addr;
  logic [DW-1:0] desc_addr_q;
  logic          desc_we;
  desc_t         desc_wd;
  logic          off_we;
  logic [DW-1:0] off_wa;
  logic [16:0]   off_wd;

  assign head_addr = DW'(32'(pidx) * 32'(RING_DEPTH) + 32'(slot_rd.head));
  assign tail_addr = DW'(32'(pidx) * 32'(RING_DEPTH) + 32'(slot_rd.tail));

  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[tail_addr] <= desc_wd;
    if (off_we) off_mem[off_wa] <= off_wd;
    if (cmd.desc_rd) begin
      desc_rd     <= desc_mem[head_addr];
      off_rd      <= off_mem[head_addr];
      desc_addr_q <= head_addr;
    end
  end

  // Ring pointer arithmetic.
  logic [HW-1:0] head_inc;
  logic [HW-1:0] tail_inc;

  assign head_inc = (slot_rd.head == HW'(RING_DEPTH - 1)) ? '0 : slot_rd.head + HW'(1);
  assign tail_inc = (slot_rd.tail == HW'(RING_DEPTH - 1)) ? '0 : slot_rd.tail + HW'(1);

  // Lookup-stage decision.
  rsp_t  lk_rsp;
  logic  lk_slot_we;
  slot_t lk_slot_wd;
  logic  lk_desc_we;
  logic  need_desc;
  logic  not_udp;
  logic  ring_full;

  assign not_udp   = (req_q.frame_length < HDR_LEN) || (req_q.ip_protocol != PROTO_UDP);
  assign ring_full = slot_rd.count >= CW'(RING_DEPTH);

  always_comb begin
    lk_rsp     = '0;
    lk_slot_we = 1'b0;
    lk_slot_wd = slot_rd;
    lk_desc_we = 1'b0;
    need_desc  = 1'b0;
    unique case (req_q.opcode)
      OP_DELIVER: begin
        lk_rsp.out_handle     = req_q.frame_handle;
        lk_rsp.release_handle = 1'b1;
        priority if (not_udp) begin
          lk_rsp.status = ST_NOT_UDP;
        end else if (!port_ok) begin
          lk_rsp.status = ST_BAD_PORT;
        end else if (!slot_rd.bound) begin
          lk_rsp.status = ST_UNBOUND;
        end else if (ring_full) begin
          lk_rsp.status = ST_FULL;
        end else if (req_q.frame_length == HDR_LEN) begin
          lk_rsp.status = ST_EMPTY_FRM;
        end else begin
          lk_rsp.status         = ST_OK;
          lk_rsp.release_handle = 1'b0;
          lk_slot_we            = 1'b1;
          lk_slot_wd.tail       = tail_inc;
          lk_slot_wd.count      = slot_rd.count + CW'(1);
          lk_desc_we            = 1'b1;
        end
      end
      OP_BIND: begin
        priority if (!port_ok) begin
          lk_rsp.status = ST_BAD_PORT;
        end else if (slot_rd.bound) begin
          lk_rsp.status = ST_BOUND;
        end else begin
          lk_rsp.status = ST_OK;
          lk_slot_we    = 1'b1;
          lk_slot_wd    = '{bound: 1'b1, head: '0, tail: '0, count: '0};
        end
      end
      OP_UNBIND: begin
        priority if (!port_ok) begin
          lk_rsp.status = ST_BAD_PORT;
        end else if (!slot_rd.bound) begin
          lk_rsp.status = ST_UNBOUND;
        end else begin
          lk_rsp.status    = ST_OK;
          lk_slot_we       = 1'b1;
          lk_slot_wd.bound = 1'b0;
        end
      end
      OP_RECEIVE: begin
        priority if (!port_ok) begin
          lk_rsp.status = ST_BAD_PORT;
        end else if (!slot_rd.bound) begin
          lk_rsp.status = ST_UNBOUND;
        end else if (slot_rd.count == '0) begin
          lk_rsp.status = ST_RING_EMPTY;
        end else begin
          need_desc = 1'b1;
        end
      end
      default: lk_rsp.status = ST_OK;
    endcase
  end

  assign sts.need_desc = need_desc;

  assign desc_wd = '{handle:  req_q.frame_handle,
                     end_off: IP_UDP_BASE + 17'(req_q.udp_length),
                     sip:     req_q.source_ip,
                     sport:   req_q.source_port};

  // Descriptor-stage decision.
  logic [16:0] rem;
  logic        fits;
  rsp_t        ds_rsp;
  slot_t       ds_slot_wd;

  assign rem  = (desc_rd.end_off > off_rd) ? desc_rd.end_off - off_rd : '0;
  assign fits = rem <= 17'(req_q.max_length);

  always_comb begin
    ds_rsp                 = '0;
    ds_rsp.status          = ST_OK;
    ds_rsp.out_handle      = desc_rd.handle;
    ds_rsp.release_handle  = fits;
    ds_rsp.out_source_ip   = desc_rd.sip;
    ds_rsp.out_source_port = desc_rd.sport;
    ds_rsp.payload_offset  = off_rd;
    ds_rsp.byte_count      = fits ? rem[12:0] : req_q.max_length;
    ds_slot_wd             = slot_rd;
    ds_slot_wd.head        = head_inc;
    ds_slot_wd.count       = slot_rd.count - CW'(1);
  end

  // Write port selection.
  always_comb begin
    slot_we = 1'b0;
    slot_wa = pidx;
    slot_wd = lk_slot_wd;
    priority if (cmd.clr_step) begin
      slot_we = 1'b1;
      slot_wa = clr_idx;
      slot_wd = '0;
    end else if (cmd.finish_lookup) begin
      slot_we = lk_slot_we;
    end else if (cmd.finish_desc) begin
      slot_we = fits;
      slot_wd = ds_slot_wd;
    end else begin
      // No table write in any other cycle.
      slot_we = 1'b0;
    end
  end

  assign desc_we = cmd.finish_lookup && lk_desc_we;
  assign off_we  = desc_we || (cmd.finish_desc && !fits);
  assign off_wa  = desc_we ? tail_addr : desc_addr_q;
  assign off_wd  = desc_we ? 17'(HDR_LEN) : off_rd + 17'(req_q.max_length);

  // Output register.
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish_lookup || cmd.finish_desc) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_lookup) begin
      rsp_out <= lk_rsp;
    end else if (cmd.finish_desc) begin
      rsp_out <= ds_rsp;
    end
  end

endmodule

@@ hw/rtl/udp_port_receive_queues_top.sv @@
// Sequence: a word is latched in the idle state; bind, unbind, deliver and failed
// receives give their result in the lookup state, a receive that reads a descriptor
// in the descriptor state; either waits while the output register is still held.
// Flow: a new word is taken only after the last one has written its result.
// Reset: the port table is swept one port per cycle with ready low; the descriptor
// store is not cleared, as only written entries are ever read.
module udp_port_receive_queues_top import upr_pkg::*; #(
  parameter int unsigned PORT_SLOTS = PORT_SLOTS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  upr_req_if.sink  req,
  upr_rsp_if.source rsp
);

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;
  req_t req_word;
  rsp_t rsp_word;

  // Gather the request fields into one word for the datapath.
  assign req_word = '{opcode:       opcode_t'(req.opcode),
                      port:         req.port,
                      frame_handle: req.frame_handle,
                      frame_length: req.frame_length,
                      ip_protocol:  req.ip_protocol,
                      udp_length:   req.udp_length,
                      source_ip:    req.source_ip,
                      source_port:  req.source_port,
                      max_length:   req.max_length};

  // The controller sequences each word through lookup and, for a receive that
  // finds a descriptor, a second memory stage.
  upr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the port table, the descriptor store and the output register,
  // so a finished result may wait while the next word is already being taken.
  upr_dp #(
    .PORT_SLOTS (PORT_SLOTS),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req_word),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_out   (rsp_word),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  // Spread the result word over the response channel.
  assign rsp.status          = rsp_word.status;
  assign rsp.out_handle      = rsp_word.out_handle;
  assign rsp.release_handle  = rsp_word.release_handle;
  assign rsp.out_source_ip   = rsp_word.out_source_ip;
  assign rsp.out_source_port = rsp_word.out_source_port;
  assign rsp.payload_offset  = rsp_word.payload_offset;
  assign rsp.byte_count      = rsp_word.byte_count;

endmodule
